// ----- hw/rtl/stis_pkg.sv -----
package stis_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_SIDE_RIGHT   = 3'd0;
  localparam logic [2:0] CFG_BIG_MODE     = 3'd1;
  localparam logic [2:0] CFG_STRIP_LENGTH = 3'd2;
  localparam logic [2:0] CFG_NORMAL_PER   = 3'd3;
  localparam logic [2:0] CFG_FIRST_PER    = 3'd4;
  localparam logic [2:0] CFG_FADE_IN      = 3'd5;
  localparam logic [2:0] CFG_HOLD         = 3'd6;
  localparam logic [2:0] CFG_BASE_COLOR   = 3'd7;

  // Configuration reset values
  localparam logic [9:0]  RST_STRIP_LENGTH = 10'd64;
  localparam logic [11:0] RST_NORMAL_PER   = 12'd1200;
  localparam logic [11:0] RST_FIRST_PER    = 12'd3000;
  localparam logic [11:0] RST_FADE_IN      = 12'd250;
  localparam logic [15:0] RST_HOLD         = 16'd1000;
  localparam logic [23:0] RST_BASE_COLOR   = 24'd16742400;

  // Item kinds
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;
  localparam logic [1:0] MODE_PIXEL = 2'd3;

  // Fixed-point and timing constants
  localparam logic [15:0] FULL_Q15     = 16'd32768;
  localparam logic [31:0] QUICK_OFF_MS = 32'd1000;
  localparam logic [31:0] BACKDATE_MS  = 32'd600;

  // Serial divider request and response
  typedef struct packed {
    logic        start;
    logic [5:0]  steps;
    logic [11:0] divisor;
    logic [11:0] rem_init;
    logic [31:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [11:0] rem;
    logic [14:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_HALF,
    S_FADE,
    S_MUL,
    S_PSUB,
    S_PDIV,
    S_COLOR,
    S_DONE
  } state_t;

endpackage

// ----- hw/rtl/stis_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Dividend bits enter MSB first; the remainder starts at rem_init (must be below divisor).
module stis_div import stis_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [11:0] dvs_r, dvs_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [14:0] quo_r, quo_nxt;

  logic [12:0] trial;
  logic [12:0] diff;
  logic        fits;

  // One trial subtraction
  assign trial = {rem_r, dvd_r[31]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      dvs_nxt  = req.divisor;
      dvd_nxt  = req.dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[11:0] : trial[11:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      quo_nxt = {quo_r[13:0], fits};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign rsp.quo  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

endmodule

// ----- hw/rtl/sequential_turn_indicator_sweep_unit.sv -----
// Turn-indicator sweep generator. One item in flight; the next is taken once a result is queued.
// Tick and set-active items do not use the divider. Frame items may run a 32-bit phase modulo
// and a 15-bit fade quotient through the bit-serial divider, which is the limiting unit; pixel
// items may run a 15-bit quotient through it too.
// Reset: rst_n synchronous, active low; state and configuration return to defaults at once,
// no clearing pass.
module sequential_turn_indicator_sweep_unit import stis_pkg::*; #(
  parameter int REGION_LEDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // active_level[0], pixel_index[8:1], peer_active[9], peer_start_ms[41:10], zero[47:42]
  input  logic [47:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_enable[0], led_address[9:1], red[17:10], green[25:18], blue[33:26],
  // is_active[34], is_synced[35], zero[39:36]
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam logic signed [10:0] REGION_S = 11'(REGION_LEDS);

  // Configuration
  logic        side_right_r, big_mode_r;
  logic [9:0]  strip_len_r;
  logic [11:0] normal_per_r, first_per_r, fade_in_r;
  logic [15:0] hold_ms_r;
  logic [23:0] base_color_r;

  // Indicator state
  logic [31:0] now_r, cycle_start_r, hold_start_r;
  logic [11:0] period_r;
  logic [15:0] fade_r;
  logic        active_r, synced_r, hold_valid_r;

  // Current item
  logic [1:0]  mode_r;
  logic        level_r, peer_act_r;
  logic [7:0]  idx_r;
  logic [31:0] peer_start_r;

  // Working registers
  logic [11:0] phase_r;
  logic [8:0]  region_r;
  logic [24:0] prod_r;
  logic [15:0] factor_r;
  logic [8:0]  addr_r;
  logic        addr_ok_r;
  logic        res_we_r;
  logic [8:0]  res_addr_r;
  logic [23:0] res_color_r;

  logic        out_valid_r;
  logic [39:0] out_data_r;

  state_t   state_r, state_nxt;
  div_req_t div_req;
  div_rsp_t div_rsp;

  stis_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Hold timing
  logic [31:0] hold_elapsed;
  logic        hold_live, quick_off, blank_path;
  assign hold_elapsed = now_r - hold_start_r;
  assign hold_live    = hold_valid_r && !(hold_elapsed > {16'b0, hold_ms_r});
  assign quick_off    = hold_elapsed <= QUICK_OFF_MS;
  assign blank_path   = hold_live && !active_r;

  // Region size and bounds
  logic signed [10:0] region_s;
  logic               region_ok;
  assign region_s  = big_mode_r ? ($signed({2'b0, strip_len_r[9:1]}) - REGION_S) : REGION_S;
  assign region_ok = (region_s > 11'sd1) && ($signed({3'b0, idx_r}) < region_s);

  // LED address
  logic signed [11:0] n_s, half_s, i_s, r_s, addr_s;
  logic               addr_ok;
  assign n_s    = $signed({2'b0, strip_len_r});
  assign half_s = $signed({3'b0, strip_len_r[9:1]});
  assign i_s    = $signed({4'b0, idx_r});
  assign r_s    = {region_s[10], region_s};

  always_comb begin
    if (!big_mode_r || blank_path) begin
      addr_s = side_right_r ? (n_s - 12'sd1 - i_s) : i_s;
    end else begin
      addr_s = side_right_r ? (half_s + r_s - 12'sd1 - i_s) : (half_s - r_s + i_s);
    end
  end

  assign addr_ok = (addr_s >= 12'sd0) && (addr_s < n_s) && (addr_s <= 12'sd511);

  // Sweep numerator: fade*R - (R-i)*1.0
  logic [8:0]         rmi;
  logic signed [26:0] num_s;
  logic               num_big;
  assign rmi     = region_r - {1'b0, idx_r};
  assign num_s   = $signed({2'b0, prod_r}) - $signed({3'b0, rmi, 15'b0});
  assign num_big = num_s[25:0] >= {3'b0, idx_r, 15'b0};

  // Frame phase tests
  logic [31:0] cyc_elapsed;
  logic        first_half, phase_ge_fade;
  assign cyc_elapsed   = now_r - cycle_start_r;
  assign first_half    = phase_r < {1'b0, period_r[11:1]};
  assign phase_ge_fade = phase_r >= fade_in_r;

  // Channel scaling
  logic [23:0] red_p, green_p, blue_p;
  assign red_p   = 24'(base_color_r[23:16]) * 24'(factor_r);
  assign green_p = 24'(base_color_r[15:8]) * 24'(factor_r);
  assign blue_p  = 24'(base_color_r[7:0]) * 24'(factor_r);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, handshake and divider requests
  always_comb begin
    state_nxt        = state_r;
    in_tready        = 1'b0;
    div_req.start    = 1'b0;
    div_req.steps    = 6'd15;
    div_req.divisor  = fade_in_r;
    div_req.rem_init = phase_r;
    div_req.dividend = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (mode_r) inside
          MODE_TICK, MODE_SET: state_nxt = S_DONE;
          MODE_FRAME: begin
            if (!active_r && !hold_valid_r) begin
              state_nxt = S_DONE;
            end else if (period_r == '0) begin
              state_nxt = S_HALF;
            end else begin
              div_req.start    = 1'b1;
              div_req.steps    = 6'd32;
              div_req.divisor  = period_r;
              div_req.rem_init = '0;
              div_req.dividend = cyc_elapsed;
              state_nxt        = S_MOD;
            end
          end
          MODE_PIXEL: begin
            if ((!active_r && !hold_valid_r) || !region_ok || blank_path) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_MUL;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_MOD: begin
        if (div_rsp.done) state_nxt = S_HALF;
      end
      S_HALF: begin
        if (first_half && !phase_ge_fade) begin
          div_req.start = 1'b1;
          state_nxt     = S_FADE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FADE: begin
        if (div_rsp.done) state_nxt = S_DONE;
      end
      S_MUL: state_nxt = S_PSUB;
      S_PSUB: begin
        if (num_s < 27'sd0 || idx_r == '0 || num_big) begin
          state_nxt = S_COLOR;
        end else begin
          div_req.start    = 1'b1;
          div_req.divisor  = {4'b0, idx_r};
          div_req.rem_init = {4'b0, num_s[22:15]};
          div_req.dividend = {num_s[14:0], 17'b0};
          state_nxt        = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) state_nxt = S_COLOR;
      end
      S_COLOR: state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_right_r <= 1'b0;
      big_mode_r   <= 1'b0;
      strip_len_r  <= RST_STRIP_LENGTH;
      normal_per_r <= RST_NORMAL_PER;
      first_per_r  <= RST_FIRST_PER;
      fade_in_r    <= RST_FADE_IN;
      hold_ms_r    <= RST_HOLD;
      base_color_r <= RST_BASE_COLOR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SIDE_RIGHT:   side_right_r <= cfg_wdata[0];
        CFG_BIG_MODE:     big_mode_r   <= cfg_wdata[0];
        CFG_STRIP_LENGTH: strip_len_r  <= cfg_wdata[9:0];
        CFG_NORMAL_PER:   normal_per_r <= cfg_wdata[11:0];
        CFG_FIRST_PER:    first_per_r  <= cfg_wdata[11:0];
        CFG_FADE_IN:      fade_in_r    <= cfg_wdata[11:0];
        CFG_HOLD:         hold_ms_r    <= cfg_wdata[15:0];
        CFG_BASE_COLOR:   base_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Indicator state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      cycle_start_r <= '0;
      hold_start_r  <= '0;
      period_r      <= RST_NORMAL_PER;
      fade_r        <= '0;
      active_r      <= 1'b0;
      synced_r      <= 1'b0;
      hold_valid_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_EXEC: begin
          unique case (mode_r)
            MODE_TICK: now_r <= now_r + 32'd1;
            MODE_SET: begin
              if (level_r != active_r) begin
                active_r <= level_r;
                if (level_r) begin
                  hold_start_r  <= now_r;
                  hold_valid_r  <= 1'b1;
                  period_r      <= first_per_r;
                  cycle_start_r <= now_r;
                end else begin
                  // quick switch-off re-arms the blanking hold
                  fade_r        <= '0;
                  cycle_start_r <= '0;
                  hold_valid_r  <= hold_valid_r && quick_off;
                  if (hold_valid_r && quick_off) hold_start_r <= now_r;
                  synced_r      <= 1'b0;
                end
              end
            end
            MODE_FRAME: begin
              if (!active_r && !hold_valid_r) fade_r <= '0;
            end
            MODE_PIXEL: begin
              if (active_r || hold_valid_r) hold_valid_r <= hold_live;
            end
            default: ;
          endcase
        end
        S_HALF: begin
          if (first_half) begin
            if (phase_ge_fade) fade_r <= FULL_Q15;
          end else begin
            // off-half: switch to normal period and resync once
            fade_r <= '0;
            if (period_r != normal_per_r) begin
              period_r <= normal_per_r;
              if (peer_act_r && !synced_r) begin
                cycle_start_r <= peer_start_r;
                synced_r      <= 1'b1;
              end else if (!synced_r) begin
                cycle_start_r <= now_r - BACKDATE_MS;
              end
            end
          end
        end
        S_FADE: begin
          if (div_rsp.done) fade_r <= {1'b0, div_rsp.quo};
        end
        default: ;
      endcase
    end
  end

  // Item capture and pixel datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_r       <= in_tuser;
          level_r      <= in_tdata[0];
          idx_r        <= in_tdata[8:1];
          peer_act_r   <= in_tdata[9];
          peer_start_r <= in_tdata[41:10];
          res_we_r     <= 1'b0;
          res_addr_r   <= '0;
          res_color_r  <= '0;
        end
      end
      S_EXEC: begin
        phase_r   <= '0;
        addr_r    <= addr_s[8:0];
        addr_ok_r <= addr_ok;
        region_r  <= region_s[8:0];
        // blanking writes black
        if (mode_r == MODE_PIXEL && (active_r || hold_valid_r) && region_ok && blank_path) begin
          res_we_r   <= addr_ok;
          res_addr_r <= addr_ok ? addr_s[8:0] : '0;
        end
      end
      S_MOD: begin
        if (div_rsp.done) phase_r <= div_rsp.rem;
      end
      S_MUL: prod_r <= 25'(fade_r) * 25'(region_r);
      S_PSUB: begin
        if (num_s < 27'sd0) begin
          factor_r <= '0;
        end else if (idx_r == '0 || num_big) begin
          factor_r <= FULL_Q15;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) factor_r <= {1'b0, div_rsp.quo};
      end
      S_COLOR: begin
        res_we_r <= addr_ok_r;
        if (addr_ok_r) begin
          res_addr_r  <= addr_r;
          res_color_r <= {red_p[22:15], green_p[22:15], blue_p[22:15]};
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_data_r <= {4'b0, synced_r, active_r, res_color_r[7:0], res_color_r[15:8],
                     res_color_r[23:16], res_addr_r, res_we_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_fade_range: assert property (@(posedge clk) disable iff (!rst_n)
    fade_r <= FULL_Q15)
    else $error("fade level above full scale");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_MOD || state_r == S_FADE || state_r == S_PDIV))
    else $error("divider finished with no waiting state");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COLOR |-> factor_r <= FULL_Q15)
    else $error("sweep factor above full scale");

  a_no_write_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> out_tdata[33:1] == '0)
    else $error("address or color set on an item with no write");

endmodule

// ----- tb/sv/tb_sequential_turn_indicator_sweep_unit.sv -----
`timescale 1ns / 100ps

module tb_sequential_turn_indicator_sweep_unit;
  import stis_pkg::*;

  localparam int REGION_LEDS = 32;
  localparam int unsigned ONE_Q15 = FULL_Q15;

  // Input item, packed as on in_tdata
  typedef struct packed {
    logic [31:0] peer_start;
    logic        peer_act;
    logic [7:0]  idx;
    logic        level;
  } sweep_item_t;

  // Result item, packed as on out_tdata[35:0]
  typedef struct packed {
    logic       synced;
    logic       active;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [8:0] addr;
    logic       wr;
  } led_word_t;

  typedef struct {
    logic        side_right;
    logic        big_mode;
    logic [9:0]  strip_len;
    logic [11:0] normal_per;
    logic [11:0] first_per;
    logic [11:0] fade_in;
    logic [15:0] hold;
    logic [23:0] color;
  } lamp_cfg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // active_level[0], pixel_index[8:1], peer_active[9],
                                // peer_start_ms[41:10], zero[47:42]
  logic [1:0]  in_tuser = '0;   // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // write_enable[0], led_address[9:1], red[17:10],
                                // green[25:18], blue[33:26], is_active[34],
                                // is_synced[35], zero[39:36]
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = CFG_SIDE_RIGHT;
  logic [23:0] cfg_wdata = '0;

  // Predictor copy of configuration and state
  lamp_cfg_t   lamp;
  logic [31:0] ms_clock;
  logic [31:0] cycle_origin;
  logic [31:0] hold_origin;
  logic [11:0] blink_period;
  logic [15:0] fade_q15;
  logic        lit;
  logic        peer_locked;
  logic        hold_armed;

  led_word_t   pending_leds[$];
  int          mismatch_count = 0;
  int          results_seen = 0;
  bit          steady = 1'b0;

  sequential_turn_indicator_sweep_unit #(.REGION_LEDS(REGION_LEDS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_sweep_model();
    lamp.side_right = 1'b0;
    lamp.big_mode   = 1'b0;
    lamp.strip_len  = RST_STRIP_LENGTH;
    lamp.normal_per = RST_NORMAL_PER;
    lamp.first_per  = RST_FIRST_PER;
    lamp.fade_in    = RST_FADE_IN;
    lamp.hold       = RST_HOLD;
    lamp.color      = RST_BASE_COLOR;
    ms_clock     = '0;
    cycle_origin = '0;
    hold_origin  = '0;
    blink_period = RST_NORMAL_PER;
    fade_q15     = '0;
    lit          = 1'b0;
    peer_locked  = 1'b0;
    hold_armed   = 1'b0;
  endfunction

  // Advance the sweep state by one item and return the LED word it produces
  function automatic led_word_t sweep_step(logic [1:0] kind, sweep_item_t it);
    led_word_t   res;
    logic [31:0] phase;
    logic [31:0] frac;
    int          strip;
    int          region;
    int          pos;
    int          addr;
    int          num;
    int          fade_i;
    int unsigned factor;
    res = '0;
    case (kind)
      MODE_TICK: begin
        ms_clock = ms_clock + 32'd1;
      end
      MODE_SET: begin
        if (it.level != lit) begin
          lit = it.level;
          if (it.level) begin
            hold_origin  = ms_clock;
            hold_armed   = 1'b1;
            blink_period = lamp.first_per;
            cycle_origin = ms_clock;
          end else begin
            fade_q15     = '0;
            cycle_origin = '0;
            // quick switch-off re-arms the blanking hold
            if (hold_armed && (ms_clock - hold_origin) <= QUICK_OFF_MS)
              hold_origin = ms_clock;
            else
              hold_armed = 1'b0;
            peer_locked = 1'b0;
          end
        end
      end
      MODE_FRAME: begin
        if (!lit && !hold_armed) begin
          fade_q15 = '0;
        end else begin
          phase = (blink_period == 0) ? 32'd0
                                      : (ms_clock - cycle_origin) % {20'd0, blink_period};
          if (phase < {21'd0, blink_period[11:1]}) begin
            frac = (lamp.fade_in == 0) ? ONE_Q15
                                       : (phase * ONE_Q15) / {20'd0, lamp.fade_in};
            fade_q15 = (frac > ONE_Q15) ? FULL_Q15 : frac[15:0];
          end else begin
            fade_q15 = '0;
            // first off-half: drop to normal period and resync
            if (blink_period != lamp.normal_per) begin
              blink_period = lamp.normal_per;
              if (it.peer_act && !peer_locked) begin
                cycle_origin = it.peer_start;
                peer_locked  = 1'b1;
              end else if (!peer_locked) begin
                cycle_origin = ms_clock - BACKDATE_MS;
              end
            end
          end
        end
      end
      default: begin
        if (lit || hold_armed) begin
          if (hold_armed && (ms_clock - hold_origin) > {16'd0, lamp.hold})
            hold_armed = 1'b0;
          strip  = lamp.strip_len;
          pos    = it.idx;
          fade_i = fade_q15;
          factor = 0;
          region = lamp.big_mode ? strip / 2 - REGION_LEDS : REGION_LEDS;
          if (region > 1 && pos < region) begin
            if (hold_armed && !lit) begin
              // blanking: black at the plain strip position
              addr = lamp.side_right ? strip - pos - 1 : pos;
            end else begin
              num = fade_i * region - (region - pos) * int'(ONE_Q15);
              if (num >= 0) begin
                factor = (pos == 0) ? ONE_Q15 : num / pos;
                if (factor > ONE_Q15) factor = ONE_Q15;
              end
              if (!lamp.big_mode)
                addr = lamp.side_right ? strip - pos - 1 : pos;
              else
                addr = lamp.side_right ? strip / 2 + region - pos - 1
                                       : strip / 2 - region + pos;
            end
            if (addr >= 0 && addr < strip && addr <= 511) begin
              res.wr    = 1'b1;
              res.addr  = addr[8:0];
              res.red   = 8'((lamp.color[23:16] * factor) >> 15);
              res.green = 8'((lamp.color[15:8] * factor) >> 15);
              res.blue  = 8'((lamp.color[7:0] * factor) >> 15);
            end
          end
        end
      end
    endcase
    res.active = lit;
    res.synced = peer_locked;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [35:0] got, logic [35:0] want);
    $display("ERROR: result %0d %s: got 0x%0h expected 0x%0h", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Result checker
  always @(posedge clk) begin : led_check
    led_word_t got;
    led_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[35:0];
      if (pending_leds.size() == 0) begin
        report_mismatch("result with no item pending", got, '0);
      end else begin
        want = pending_leds.pop_front();
        if (got.wr !== want.wr) report_mismatch("write_enable", got.wr, want.wr);
        if (got.addr !== want.addr) report_mismatch("led_address", got.addr, want.addr);
        if (got.red !== want.red) report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.active !== want.active) report_mismatch("is_active", got.active, want.active);
        if (got.synced !== want.synced) report_mismatch("is_synced", got.synced, want.synced);
      end
      results_seen++;
    end
  end

  // Result-side stalls
  initial begin : sink_pacing
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  // Send one item, update the prediction on acceptance, then maybe idle
  task automatic send_item(logic [1:0] kind, logic level, logic [7:0] idx,
                           logic peer_act, logic [31:0] peer_start);
    sweep_item_t it;
    int          gap;
    it = '{peer_start: peer_start, peer_act: peer_act, idx: idx, level: level};
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_leds.push_back(sweep_step(kind, it));
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold input back until every pending result is in
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic program_lamp(lamp_cfg_t c);
    wait_drain();
    write_reg(CFG_SIDE_RIGHT, c.side_right);
    write_reg(CFG_BIG_MODE, c.big_mode);
    write_reg(CFG_STRIP_LENGTH, c.strip_len);
    write_reg(CFG_NORMAL_PER, c.normal_per);
    write_reg(CFG_FIRST_PER, c.first_per);
    write_reg(CFG_FADE_IN, c.fade_in);
    write_reg(CFG_HOLD, c.hold);
    write_reg(CFG_BASE_COLOR, c.color);
    cfg_we <= 1'b0;
    lamp = c;
  endtask

  function automatic lamp_cfg_t random_lamp();
    lamp_cfg_t c;
    int        r;
    c.side_right = $urandom_range(0, 1);
    c.big_mode   = $urandom_range(0, 1);
    r = $urandom_range(0, 9);
    c.strip_len = (r == 0) ? 10'd0 : (r == 1) ? 10'd512 :
                  (r < 4) ? 10'($urandom_range(0, 70)) : 10'($urandom_range(60, 512));
    r = $urandom_range(0, 19);
    c.normal_per = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : 12'($urandom_range(2, 40));
    r = $urandom_range(0, 19);
    c.first_per = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : 12'($urandom_range(2, 60));
    r = $urandom_range(0, 19);
    c.fade_in = (r == 0) ? 12'd0 : (r == 1) ? 12'd4095 : 12'($urandom_range(1, 20));
    r = $urandom_range(0, 19);
    c.hold = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF : 16'($urandom_range(0, 60));
    r = $urandom_range(0, 19);
    c.color = (r < 2) ? 24'hFFFFFF : (r == 2) ? 24'h0 : 24'($urandom);
    return c;
  endfunction

  // Basic sweep with a short blink period: idle, switch-on, fade, sync, quick off
  task automatic test_first_sweep();
    program_lamp('{side_right: 1'b0, big_mode: 1'b0, strip_len: 10'd64,
                   normal_per: 12'd4, first_per: 12'd8, fade_in: 12'd2,
                   hold: 16'hFFFF, color: 24'hFFFFFF});
    send_item(MODE_PIXEL, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_SET, 1'b1, 8'd0, 1'b0, 32'd0);
    send_item(MODE_SET, 1'b1, 8'd0, 1'b0, 32'd0);
    send_item(MODE_TICK, 1'b0, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_item(MODE_FRAME, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd31, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd255, 1'b0, 32'd0);
    repeat (3) send_item(MODE_TICK, 1'b1, 8'h00, 1'b0, 32'd0);
    // off-half with an active peer: lock to its start
    send_item(MODE_FRAME, 1'b0, 8'd0, 1'b1, 32'hFFFF_FFFF);
    send_item(MODE_SET, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd3, 1'b0, 32'd0);
    send_item(MODE_FRAME, 1'b0, 8'd0, 1'b0, 32'd0);
  endtask

  // Zero period, zero fade time, one-LED region, hold expiry, address past strip end
  task automatic test_corner_configs();
    program_lamp('{side_right: 1'b1, big_mode: 1'b1, strip_len: 10'd66,
                   normal_per: 12'd0, first_per: 12'd4, fade_in: 12'd0,
                   hold: 16'd0, color: 24'h123456});
    send_item(MODE_SET, 1'b1, 8'd0, 1'b0, 32'd0);
    send_item(MODE_FRAME, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_TICK, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_TICK, 1'b0, 8'd0, 1'b0, 32'd0);
    // off-half without a peer: backdate the start
    send_item(MODE_FRAME, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_FRAME, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd0, 1'b0, 32'd0);
    program_lamp('{side_right: 1'b0, big_mode: 1'b0, strip_len: 10'd10,
                   normal_per: 12'd0, first_per: 12'd4, fade_in: 12'd0,
                   hold: 16'd0, color: 24'h123456});
    send_item(MODE_PIXEL, 1'b0, 8'd20, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd5, 1'b0, 32'd0);
  endtask

  // Switch-off long after switch-on drops the hold instead of re-arming it
  task automatic test_late_release();
    steady = 1'b1;
    program_lamp('{side_right: 1'b0, big_mode: 1'b0, strip_len: 10'd64,
                   normal_per: 12'd20, first_per: 12'd30, fade_in: 12'd5,
                   hold: 16'hFFFF, color: 24'($urandom)});
    send_item(MODE_SET, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_SET, 1'b1, 8'd0, 1'b0, 32'd0);
    repeat (QUICK_OFF_MS + 1) send_item(MODE_TICK, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_FRAME, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_SET, 1'b0, 8'd0, 1'b0, 32'd0);
    send_item(MODE_PIXEL, 1'b0, 8'd4, 1'b0, 32'd0);
    steady = 1'b0;
  endtask

  // Random mix: ticks, frames, pixel queries mostly inside the region, on/off toggles
  task automatic run_random_block(int count);
    int         r;
    int         region;
    int         strip;
    logic       lv;
    logic [7:0] idx;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_drain();
      r      = $urandom_range(0, 99);
      strip  = lamp.strip_len;
      region = lamp.big_mode ? strip / 2 - REGION_LEDS : REGION_LEDS;
      if (r < 45) begin
        send_item(MODE_TICK, $urandom_range(0, 1), 8'($urandom), $urandom_range(0, 1),
                  $urandom);
      end else if (r < 63) begin
        send_item(MODE_FRAME, $urandom_range(0, 1), 8'($urandom), $urandom_range(0, 1),
                  $urandom_range(0, 1) ? $urandom : ms_clock - $urandom_range(0, 100));
      end else if (r < 90) begin
        if (region > 1 && $urandom_range(0, 4) != 0)
          idx = $urandom_range(0, (region > 256) ? 255 : region - 1);
        else
          idx = $urandom_range(0, 255);
        send_item(MODE_PIXEL, $urandom_range(0, 1), idx, $urandom_range(0, 1), $urandom);
      end else begin
        lv = ($urandom_range(0, 3) != 0) ? !lit : $urandom_range(0, 1);
        send_item(MODE_SET, lv, 8'($urandom), $urandom_range(0, 1), $urandom);
      end
    end
  endtask

  task automatic test_random_sweeps();
    for (int blk = 0; blk < 8; blk++) begin
      steady = (blk == 0) || ($urandom_range(0, 3) == 0);
      program_lamp(random_lamp());
      run_random_block(100);
    end
    steady = 1'b0;
  endtask

  initial begin
    reset_sweep_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sweep();
    test_corner_configs();
    test_late_release();
    test_random_sweeps();
    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("sequential_turn_indicator_sweep_unit: match");
    else
      $display("sequential_turn_indicator_sweep_unit: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #(15_000_000);
    $display("sequential_turn_indicator_sweep_unit: mismatch");
    $finish;
  end

endmodule

// ----- sequential_turn_indicator_sweep_unit.f -----
hw/rtl/stis_pkg.sv
hw/rtl/stis_div.sv
hw/rtl/sequential_turn_indicator_sweep_unit.sv
tb/sv/tb_sequential_turn_indicator_sweep_unit.sv
